### design/gbn_pkg.sv
// Shared types, constants and helpers for the go-back-N sender window.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package gbn_pkg;

	localparam int WINDOW      = 10;
	localparam int MAX_PAYLOAD = 512;

	localparam int SEQ_W  = 16;
	localparam int LEN_W  = 10;
	localparam int SLOT_W = 4;
	localparam int CNT_W  = 5;
	localparam int TMR_W  = 24;
	localparam int DVD_W  = SEQ_W + 1;

	localparam logic [SEQ_W-1:0] SEQ_SPACE_RST = SEQ_W'(25601);
	localparam logic [TMR_W-1:0] TIMEOUT_RST   = TMR_W'(500000);
	localparam logic [SEQ_W-1:0] SEQ_SPACE_MIN = SEQ_W'(2);

	localparam logic CFG_SEQ_SPACE = 1'b0;
	localparam logic CFG_TIMEOUT   = 1'b1;

	typedef enum logic [1:0] {
		KIND_START = 2'd0,
		KIND_OFFER = 2'd1,
		KIND_ACK   = 2'd2,
		KIND_TICK  = 2'd3
	} in_kind_t;

	typedef enum logic [1:0] {
		OUT_SEND    = 2'd0,
		OUT_RESEND  = 2'd1,
		OUT_STATUS  = 2'd2,
		OUT_REFUSED = 2'd3
	} out_kind_t;

	typedef enum logic [3:0] {
		B_IDLE,
		B_START_W,
		B_OFFER_W1,
		B_REFUSE,
		B_OFFER_W2,
		B_ACK_ISSUE,
		B_ACK_W,
		B_ACK_DONE,
		B_BURST
	} back_state_t;

	typedef struct packed {
		in_kind_t          op;
		logic [SEQ_W-1:0]  start_seq;
		logic [LEN_W-1:0]  len;
		logic [SEQ_W-1:0]  ack;
		logic              len_ok;
	} cmd_t;

	typedef struct packed {
		out_kind_t         okind;
		logic [SEQ_W-1:0]  seq;
		logic [LEN_W-1:0]  len;
		logic [SLOT_W-1:0] slot;
		logic [CNT_W-1:0]  in_flight;
		logic              matched;
		logic              all_acked;
		logic              last;
	} res_t;

	function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] p);
		logic [SLOT_W-1:0] r;
		if (p == SLOT_W'(WINDOW - 1)) begin
			r = '0;
		end else begin
			r = p + SLOT_W'(1);
		end
		return r;
	endfunction

endpackage

### design/gbn_front.sv
// Input stage: registers a word from the slave stream and classifies it.
// Depends on gbn_pkg.
`timescale 1ns / 1ps

module gbn_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [47:0]        s_tdata,
	input  logic [1:0]         s_tuser,
	output logic               push,
	output gbn_pkg::cmd_t      cmd,
	input  logic               q_ready
);

	logic          valid_s1;
	gbn_pkg::cmd_t cmd_s1;
	logic [gbn_pkg::LEN_W-1:0] len_in;

	assign len_in   = s_tdata[25:16];
	assign push     = valid_s1 && q_ready;
	assign s_tready = !valid_s1 || q_ready;
	assign cmd      = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			cmd_s1.op        <= gbn_pkg::in_kind_t'(s_tuser);
			cmd_s1.start_seq <= s_tdata[15:0];
			cmd_s1.len       <= len_in;
			cmd_s1.ack       <= s_tdata[41:26];
			cmd_s1.len_ok    <= (len_in != '0) &&
				(len_in <= gbn_pkg::LEN_W'(gbn_pkg::MAX_PAYLOAD));
		end
	end

endmodule

### design/gbn_cmdq.sv
// Two-entry command queue between the front and the back.
// Depends on gbn_pkg.
`timescale 1ns / 1ps

module gbn_cmdq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  gbn_pkg::cmd_t wr_cmd,
	output logic          not_full,
	input  logic          pop,
	output gbn_pkg::cmd_t rd_cmd,
	output logic          not_empty
);

	gbn_pkg::cmd_t entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign not_full  = (count_q != 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign rd_cmd    = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wr_cmd;
		end
	end

endmodule

### design/gbn_mod.sv
// Remainder unit: one bit per cycle, with a direct path and no serial steps when the
// dividend is below twice the divisor. Depends on gbn_pkg.
`timescale 1ns / 1ps

module gbn_mod (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [gbn_pkg::DVD_W-1:0]   dividend,
	input  logic [gbn_pkg::SEQ_W-1:0]   divisor,
	output logic                        busy,
	output logic [gbn_pkg::SEQ_W-1:0]   rem
);

	logic                        busy_q;
	logic [gbn_pkg::DVD_W-1:0]   acc_q;
	logic [gbn_pkg::DVD_W-1:0]   dvd_q;
	logic [gbn_pkg::SEQ_W-1:0]   div_q;
	logic [4:0]                  cnt_q;
	logic [gbn_pkg::DVD_W-1:0]   div_ext;
	logic [gbn_pkg::DVD_W-1:0]   diff;
	logic [gbn_pkg::DVD_W-1:0]   trial;
	logic [gbn_pkg::DVD_W-1:0]   div_q_ext;

	assign div_ext   = {1'b0, divisor};
	assign diff      = dividend - div_ext;
	assign div_q_ext = {1'b0, div_q};
	assign trial     = {acc_q[gbn_pkg::DVD_W-2:0], dvd_q[gbn_pkg::DVD_W-1]};
	assign busy      = busy_q;
	assign rem       = acc_q[gbn_pkg::SEQ_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			if (dividend < div_ext || diff < div_ext) begin
				busy_q <= 1'b0;
			end else begin
				busy_q <= 1'b1;
				cnt_q  <= 5'(gbn_pkg::DVD_W);
			end
		end else if (busy_q) begin
			cnt_q <= cnt_q - 5'd1;
			if (cnt_q == 5'd1) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= divisor;
			dvd_q <= dividend;
			if (dividend < div_ext) begin
				acc_q <= dividend;
			end else if (diff < div_ext) begin
				acc_q <= diff;
			end else begin
				acc_q <= '0;
			end
		end else if (busy_q) begin
			dvd_q <= {dvd_q[gbn_pkg::DVD_W-2:0], 1'b0};
			if (trial >= div_q_ext) begin
				acc_q <= trial - div_q_ext;
			end else begin
				acc_q <= trial;
			end
		end
	end

endmodule

### design/gbn_back.sv
// Back end: window store, sequencer for sends, ack search and resend
// bursts, and the result register. Depends on gbn_pkg and gbn_mod.
`timescale 1ns / 1ps

module gbn_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cmd_valid,
	input  gbn_pkg::cmd_t               cmd,
	output logic                        cmd_pop,
	input  logic [gbn_pkg::SEQ_W-1:0]   seq_space,
	input  logic [gbn_pkg::TMR_W-1:0]   timeout_ticks,
	output logic                        res_valid,
	input  logic                        res_ready,
	output gbn_pkg::res_t               res_out
);

	gbn_pkg::back_state_t state_q, state_d;

	logic [gbn_pkg::SEQ_W-1:0]  seq_mem [gbn_pkg::WINDOW];
	logic [gbn_pkg::LEN_W-1:0]  len_mem [gbn_pkg::WINDOW];

	gbn_pkg::cmd_t              cmd_q;
	logic [gbn_pkg::SEQ_W-1:0]  seq_q;
	logic [gbn_pkg::SLOT_W-1:0] base_q, tail_q, ptr_q;
	logic [gbn_pkg::CNT_W-1:0]  outst_q, idx_q;
	logic [gbn_pkg::SEQ_W-1:0]  next_seq_q;
	logic [gbn_pkg::TMR_W-1:0]  timer_q;
	logic                       hit_q;
	logic                       res_valid_q;
	gbn_pkg::res_t              res_q;

	logic [gbn_pkg::SEQ_W-1:0]  space_eff;
	logic                       mod_start;
	logic [gbn_pkg::DVD_W-1:0]  mod_dvd;
	logic                       mod_busy;
	logic [gbn_pkg::SEQ_W-1:0]  mod_rem;
	logic                       out_free;
	logic                       emit;
	logic                       mem_we;
	gbn_pkg::res_t              res_d;
	logic [gbn_pkg::TMR_W-1:0]  tick_next;
	logic                       refuse;
	logic                       scan_last;
	logic [gbn_pkg::CNT_W-1:0]  idx_inc;
	logic [gbn_pkg::CNT_W-1:0]  outst_after;
	logic [gbn_pkg::SEQ_W-1:0]  rd_seq;
	logic [gbn_pkg::LEN_W-1:0]  rd_len;

	assign space_eff   = (seq_space < gbn_pkg::SEQ_SPACE_MIN) ? gbn_pkg::SEQ_SPACE_MIN
		: seq_space;
	assign out_free    = !res_valid_q || res_ready;
	assign tick_next   = (timer_q == '0) ? '0 : timer_q - gbn_pkg::TMR_W'(1);
	assign refuse      = (outst_q >= gbn_pkg::CNT_W'(gbn_pkg::WINDOW)) || !cmd_q.len_ok;
	assign idx_inc     = idx_q + gbn_pkg::CNT_W'(1);
	assign scan_last   = (idx_inc == outst_q);
	assign outst_after = outst_q - idx_inc;
	assign rd_seq      = seq_mem[ptr_q];
	assign rd_len      = len_mem[ptr_q];
	assign res_valid   = res_valid_q;
	assign res_out     = res_q;

	gbn_mod u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start),
		.dividend (mod_dvd),
		.divisor  (space_eff),
		.busy     (mod_busy),
		.rem      (mod_rem)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			gbn_pkg::B_IDLE: begin
				if (cmd_valid) begin
					case (cmd.op)
						gbn_pkg::KIND_START: state_d = gbn_pkg::B_START_W;
						gbn_pkg::KIND_OFFER: state_d = gbn_pkg::B_OFFER_W1;
						gbn_pkg::KIND_ACK: begin
							state_d = (outst_q == '0) ? gbn_pkg::B_ACK_DONE
								: gbn_pkg::B_ACK_ISSUE;
						end
						default: begin
							if (outst_q != '0 && tick_next == '0) begin
								state_d = gbn_pkg::B_BURST;
							end
						end
					endcase
				end
			end
			gbn_pkg::B_START_W: begin
				if (!mod_busy && out_free) state_d = gbn_pkg::B_IDLE;
			end
			gbn_pkg::B_OFFER_W1: begin
				if (!mod_busy) begin
					state_d = refuse ? gbn_pkg::B_REFUSE : gbn_pkg::B_OFFER_W2;
				end
			end
			gbn_pkg::B_REFUSE: begin
				if (out_free) state_d = gbn_pkg::B_IDLE;
			end
			gbn_pkg::B_OFFER_W2: begin
				if (!mod_busy && out_free) state_d = gbn_pkg::B_IDLE;
			end
			gbn_pkg::B_ACK_ISSUE: state_d = gbn_pkg::B_ACK_W;
			gbn_pkg::B_ACK_W: begin
				if (!mod_busy) begin
					if (mod_rem == cmd_q.ack || scan_last) begin
						state_d = gbn_pkg::B_ACK_DONE;
					end else begin
						state_d = gbn_pkg::B_ACK_ISSUE;
					end
				end
			end
			gbn_pkg::B_ACK_DONE: begin
				if (out_free) state_d = gbn_pkg::B_IDLE;
			end
			gbn_pkg::B_BURST: begin
				if (out_free && scan_last) state_d = gbn_pkg::B_IDLE;
			end
			default: state_d = gbn_pkg::B_IDLE;
		endcase
	end

	always_comb begin
		cmd_pop   = 1'b0;
		mod_start = 1'b0;
		mod_dvd   = '0;
		emit      = 1'b0;
		mem_we    = 1'b0;
		res_d     = '0;
		unique case (state_q)
			gbn_pkg::B_IDLE: begin
				cmd_pop = cmd_valid;
				if (cmd_valid && cmd.op == gbn_pkg::KIND_START) begin
					mod_start = 1'b1;
					mod_dvd   = {1'b0, cmd.start_seq};
				end else if (cmd_valid && cmd.op == gbn_pkg::KIND_OFFER) begin
					mod_start = 1'b1;
					mod_dvd   = {1'b0, next_seq_q};
				end
			end
			gbn_pkg::B_START_W: begin
				emit            = !mod_busy && out_free;
				res_d.okind     = gbn_pkg::OUT_STATUS;
				res_d.seq       = mod_rem;
				res_d.all_acked = 1'b1;
				res_d.last      = 1'b1;
			end
			gbn_pkg::B_OFFER_W1: begin
				if (!mod_busy && !refuse) begin
					mem_we    = 1'b1;
					mod_start = 1'b1;
					mod_dvd   = {1'b0, mod_rem} + gbn_pkg::DVD_W'(cmd_q.len);
				end
			end
			gbn_pkg::B_REFUSE: begin
				emit            = out_free;
				res_d.okind     = gbn_pkg::OUT_REFUSED;
				res_d.seq       = seq_q;
				res_d.len       = cmd_q.len;
				res_d.in_flight = outst_q;
				res_d.all_acked = (outst_q == '0);
				res_d.last      = 1'b1;
			end
			gbn_pkg::B_OFFER_W2: begin
				emit            = !mod_busy && out_free;
				res_d.okind     = gbn_pkg::OUT_SEND;
				res_d.seq       = seq_q;
				res_d.len       = cmd_q.len;
				res_d.slot      = tail_q;
				res_d.in_flight = outst_q + gbn_pkg::CNT_W'(1);
				res_d.last      = 1'b1;
			end
			gbn_pkg::B_ACK_ISSUE: begin
				mod_start = 1'b1;
				mod_dvd   = {1'b0, rd_seq} + gbn_pkg::DVD_W'(rd_len);
			end
			gbn_pkg::B_ACK_W: begin
				mod_start = 1'b0;
			end
			gbn_pkg::B_ACK_DONE: begin
				emit            = out_free;
				res_d.okind     = gbn_pkg::OUT_STATUS;
				res_d.slot      = hit_q ? ptr_q : '0;
				res_d.in_flight = hit_q ? outst_after : outst_q;
				res_d.matched   = hit_q;
				res_d.all_acked = hit_q ? (outst_after == '0) : (outst_q == '0);
				res_d.last      = 1'b1;
			end
			gbn_pkg::B_BURST: begin
				emit            = out_free;
				res_d.okind     = gbn_pkg::OUT_RESEND;
				res_d.seq       = rd_seq;
				res_d.len       = rd_len;
				res_d.slot      = ptr_q;
				res_d.in_flight = outst_q;
				res_d.last      = scan_last;
			end
			default: cmd_pop = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= gbn_pkg::B_IDLE;
			base_q     <= '0;
			tail_q     <= '0;
			ptr_q      <= '0;
			outst_q    <= '0;
			idx_q      <= '0;
			next_seq_q <= '0;
			timer_q    <= '0;
			hit_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				gbn_pkg::B_IDLE: begin
					if (cmd_valid && cmd.op == gbn_pkg::KIND_ACK) begin
						ptr_q <= base_q;
						idx_q <= '0;
						hit_q <= 1'b0;
					end
					if (cmd_valid && cmd.op == gbn_pkg::KIND_TICK && outst_q != '0) begin
						if (tick_next != '0) begin
							timer_q <= tick_next;
						end else begin
							timer_q <= timeout_ticks;
							ptr_q   <= base_q;
							idx_q   <= '0;
						end
					end
				end
				gbn_pkg::B_START_W: begin
					if (emit) begin
						next_seq_q <= mod_rem;
						base_q     <= '0;
						tail_q     <= '0;
						outst_q    <= '0;
						timer_q    <= '0;
					end
				end
				gbn_pkg::B_OFFER_W2: begin
					if (emit) begin
						next_seq_q <= mod_rem;
						tail_q     <= gbn_pkg::slot_inc(tail_q);
						outst_q    <= outst_q + gbn_pkg::CNT_W'(1);
						timer_q    <= timeout_ticks;
					end
				end
				gbn_pkg::B_ACK_W: begin
					if (!mod_busy) begin
						if (mod_rem == cmd_q.ack) begin
							hit_q <= 1'b1;
						end else if (!scan_last) begin
							ptr_q <= gbn_pkg::slot_inc(ptr_q);
							idx_q <= idx_inc;
						end
					end
				end
				gbn_pkg::B_ACK_DONE: begin
					if (emit && hit_q) begin
						base_q  <= gbn_pkg::slot_inc(ptr_q);
						outst_q <= outst_after;
					end
				end
				gbn_pkg::B_BURST: begin
					if (emit) begin
						ptr_q <= gbn_pkg::slot_inc(ptr_q);
						idx_q <= idx_inc;
					end
				end
				default: hit_q <= hit_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cmd_q <= cmd;
		end
		if (state_q == gbn_pkg::B_OFFER_W1 && !mod_busy) begin
			seq_q <= mod_rem;
		end
		if (mem_we) begin
			seq_mem[tail_q] <= mod_rem;
			len_mem[tail_q] <= cmd_q.len;
		end
		if (emit) begin
			res_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (emit) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

endmodule

### design/go_back_n_sender_window.sv
// Top level of the go-back-N sender window: configuration registers,
// stream ports, and the front, queue and back. Depends on gbn_pkg, gbn_front, gbn_cmdq, gbn_back.
//
//   channel   signals                              direction
//   s_*       tvalid tready tdata[47:0] tuser[1:0]  in:  one event word
//   m_*       tvalid tready tdata[39:0] tuser[1:0]  out: result words
//             tlast
//   cfg_*     we index[0] data[23:0]               in:  register write
//
// Start and offer use the shared bit-serial remainder unit, once for a start and
// twice for an offer, with a direct path when the value is below twice the space.
// An ack runs the remainder unit once per slot searched, up to ten slots.
// A timeout's resend burst gives one word per cycle unless the output stalls.
// The front register and the two-entry queue hold up to three words, so input
// and output stall apart.
// Reset empties the window and loads the default space and timeout.
`timescale 1ns / 1ps

module go_back_n_sender_window (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // start_seq, seg_length, ack_number, zero fill
	input  logic [1:0]  s_tuser,   // kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // seq_number, length_out, slot, in_flight,
	                               // matched, all_acked, zero fill
	output logic [1:0]  m_tuser,   // out_kind
	output logic        m_tlast,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [23:0] cfg_data
);

	logic [gbn_pkg::SEQ_W-1:0] seq_space_q;
	logic [gbn_pkg::TMR_W-1:0] timeout_q;

	logic          push;
	logic          q_ready;
	logic          q_valid;
	logic          pop;
	gbn_pkg::cmd_t front_cmd;
	gbn_pkg::cmd_t q_cmd;
	gbn_pkg::res_t res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_space_q <= gbn_pkg::SEQ_SPACE_RST;
			timeout_q   <= gbn_pkg::TIMEOUT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				gbn_pkg::CFG_SEQ_SPACE: seq_space_q <= cfg_data[gbn_pkg::SEQ_W-1:0];
				default:                timeout_q   <= cfg_data;
			endcase
		end
	end

	gbn_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.push     (push),
		.cmd      (front_cmd),
		.q_ready  (q_ready)
	);

	gbn_cmdq u_cmdq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_cmd    (front_cmd),
		.not_full  (q_ready),
		.pop       (pop),
		.rd_cmd    (q_cmd),
		.not_empty (q_valid)
	);

	gbn_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_valid     (q_valid),
		.cmd           (q_cmd),
		.cmd_pop       (pop),
		.seq_space     (seq_space_q),
		.timeout_ticks (timeout_q),
		.res_valid     (m_tvalid),
		.res_ready     (m_tready),
		.res_out       (res)
	);

	assign m_tuser = res.okind;
	assign m_tlast = res.last;
	assign m_tdata = {3'b000, res.all_acked, res.matched, res.in_flight,
		res.slot, res.len, res.seq};

endmodule
